/* src/lz77_greedy_match_encoder_core_macros.svh */
// Assertion helpers for the encoder core.
// Every check is sampled on clk and is switched off while arst_n is low.
`ifndef LZ77_GREEDY_MATCH_ENCODER_CORE_MACROS_SVH
`define LZ77_GREEDY_MATCH_ENCODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZG_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lzg_pkg.sv */
`default_nettype none
package lzg_pkg;

	// Default sizes of the history ring and of the lookahead row.
	localparam int HISTORY_DEF   = 4096;
	localparam int LOOKAHEAD_DEF = 32;

	// Field and register widths.
	localparam int BYTE_W     = 8;
	localparam int WINDOW_W   = 13;
	localparam int MAXLEN_W   = 6;
	localparam int KIND_W     = 2;
	localparam int LEN_W      = 6;
	localparam int DIST_W     = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAXLEN = 1'd1;

	// Reset values of the registers.
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd4096;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 6'd32;

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ESCAPED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd2;

	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hFF;
	localparam int                MIN_MATCH = 3;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [BYTE_W-1:0] literal_value;
		logic [LEN_W-1:0]  match_length;
		logic [DIST_W-1:0] match_distance;
		logic              last_token;
	} token_item_t;

	// Controls broadcast along the row of comparator cells.
	typedef struct packed {
		logic              clear;
		logic              load;
		logic              shift;
		logic              step;
		logic              flush;
		logic [BYTE_W-1:0] in_byte;
		logic [BYTE_W-1:0] hist_byte;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* src/lzg_stream_if.sv */
`default_nettype none
interface lzg_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/lz77_greedy_match_encoder_core.sv */
// Greedy LZ77 encoder core.
// byte_in carries one uncompressed byte per beat with a last-byte flag; token_out
// carries one token per beat (literal, escaped 0xFF literal or match). The user
// must write the window and maximum match length registers through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block does not enforce it.
// A byte is taken only when no position is being coded. Once the lookahead holds
// M = min(maximum match length, LOOKAHEAD) bytes (at least one), or on the last
// byte, the head position is coded: the history memory streams W = min(window, fill)
// bytes, oldest first, one per cycle through the row of comparator cells. Each
// token then moves its coded bytes in turn from the lookahead into history. A byte
// that codes nothing returns the block to idle after the check; otherwise search,
// token and move run for each position that it codes, each time from the check.
// The token sits in an output register, so the next search runs while it waits;
// a stalled receiver holds the block only when a second token is ready.
// After the last byte the history is emptied and the next byte opens a new stream.
// Reset (arst_n low) clears all control state and sets the registers to 4096 and
// 32; history contents are not cleared and need no clearing pass.
`default_nettype none
module lz77_greedy_match_encoder_core #(
	parameter int HISTORY   = lzg_pkg::HISTORY_DEF,
	parameter int LOOKAHEAD = lzg_pkg::LOOKAHEAD_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	lzg_stream_if.sink                          byte_in,
	lzg_stream_if.source                        token_out,
	input  wire logic                           cfg_we,
	input  wire logic [lzg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lzg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lzg_pkg::*;
	`include "lz77_greedy_match_encoder_core_macros.svh"

	localparam int HAW = $clog2(HISTORY);
	localparam int HCW = $clog2(HISTORY + 1);
	localparam int LAW = $clog2(LOOKAHEAD);
	localparam int LCW = $clog2(LOOKAHEAD + 1);
	localparam int MW  = (LCW > MAXLEN_W) ? LCW : MAXLEN_W;
	localparam int CW  = (HCW > WINDOW_W) ? HCW : WINDOW_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_FIN    = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;
	localparam logic [2:0] ST_MOVE   = 3'd5;

	logic [2:0]          state_q;
	logic [WINDOW_W-1:0] window_q;
	logic [MAXLEN_W-1:0] maxlen_q;
	logic [HAW-1:0]      wp_q;
	logic [HCW-1:0]      fill_q;
	logic [LCW-1:0]      count_q;
	logic [LCW-1:0]      limit_q;
	logic [LCW-1:0]      n_q;
	logic                last_q;
	logic [HCW-1:0]      e_q;
	logic [HCW-1:0]      e_s1;
	logic                step_s1;
	logic                flush_s1;
	logic [LCW-1:0]      best_len_q;
	logic [HCW-1:0]      best_dist_q;
	logic                out_valid_q;
	token_item_t         out_q;

	cell_ctrl_t          ctrl;
	logic [BYTE_W-1:0]   hist_rdata;
	logic [HAW-1:0]      raddr;
	logic [BYTE_W-1:0]   la_byte [LOOKAHEAD];
	logic                alive   [LOOKAHEAD];
	logic                extend  [LOOKAHEAD];
	logic                dead    [LOOKAHEAD];

	logic                in_acc;
	logic [CW-1:0]       eff_c;
	logic [MW-1:0]       m_c;
	logic [MW-1:0]       thr_c;
	logic [LCW-1:0]      lim_c;
	logic                code_c;
	logic                is_match_c;
	logic [LCW-1:0]      n_c;
	logic                slot_free;
	logic                any_dead;
	logic [LAW-1:0]      sel_idx;
	logic [LCW-1:0]      cand_len;
	logic [HCW-1:0]      cand_dist;
	logic [HCW-1:0]      wp_ext;

	assign byte_in.ready = (state_q == ST_IDLE);
	assign in_acc        = byte_in.valid && byte_in.ready;
	assign slot_free     = !out_valid_q || token_out.ready;

	// Reach of the search, coding threshold and match limit.
	always_comb begin
		logic [CW-1:0] win_ext;
		logic [CW-1:0] fill_ext;
		logic [MW-1:0] mml_ext;
		logic [MW-1:0] la_ext;
		logic [MW-1:0] cnt_ext;
		win_ext  = CW'(window_q);
		fill_ext = CW'(fill_q);
		eff_c    = (win_ext < fill_ext) ? win_ext : fill_ext;
		mml_ext  = MW'(maxlen_q);
		la_ext   = MW'(LOOKAHEAD);
		m_c      = (mml_ext < la_ext) ? mml_ext : la_ext;
		thr_c    = (m_c == '0) ? MW'(1) : m_c;
		cnt_ext  = MW'(count_q);
		lim_c    = LCW'((m_c < cnt_ext) ? m_c : cnt_ext);
		code_c   = (count_q != '0) && ((cnt_ext >= thr_c) || last_q);
	end

	// History read address: the byte e positions behind the write pointer.
	assign wp_ext = HCW'(wp_q);
	assign raddr  = (wp_ext >= e_q) ? HAW'(wp_ext - e_q)
		: HAW'(wp_ext + HCW'(HISTORY) - e_q);

	// Broadcast controls for the cell row.
	always_comb begin
		ctrl           = '0;
		ctrl.clear     = (state_q == ST_CHECK);
		ctrl.load      = in_acc && (count_q < LCW'(LOOKAHEAD));
		ctrl.shift     = (state_q == ST_MOVE);
		ctrl.step      = step_s1;
		ctrl.flush     = flush_s1;
		ctrl.in_byte   = byte_in.payload.data_byte;
		ctrl.hist_byte = hist_rdata;
	end

	lzg_history_mem #(
		.DEPTH(HISTORY),
		.AW   (HAW)
	) u_hist (
		.clk  (clk),
		.we   (state_q == ST_MOVE),
		.waddr(wp_q),
		.wdata(la_byte[0]),
		.raddr(raddr),
		.rdata(hist_rdata)
	);

	// Row of comparator cells, one per lookahead byte.
	for (genvar i = 0; i < LOOKAHEAD; i++) begin : g_cell
		logic [BYTE_W-1:0] nb;
		logic              pa;
		logic              ne;
		if (i == LOOKAHEAD - 1) begin : g_end
			assign nb = '0;
			assign ne = 1'b0;
		end else begin : g_mid
			assign nb = la_byte[i+1];
			assign ne = extend[i+1];
		end
		if (i == 0) begin : g_head
			assign pa = 1'b1;
		end else begin : g_body
			assign pa = alive[i-1];
		end
		lzg_cell #(
			.IDX(i),
			.LCW(LCW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.count      (count_q),
			.limit      (limit_q),
			.next_byte  (nb),
			.prev_alive (pa),
			.next_extend(ne),
			.la_byte    (la_byte[i]),
			.alive      (alive[i]),
			.extend     (extend[i]),
			.dead       (dead[i])
		);
	end

	// Longest run ending this cycle sits in the highest cell that reports an end.
	always_comb begin
		any_dead = 1'b0;
		sel_idx  = '0;
		for (int i = 0; i < LOOKAHEAD; i++) begin
			if (dead[i]) begin
				any_dead = 1'b1;
				sel_idx  = LAW'(i);
			end
		end
		cand_len  = LCW'(sel_idx) + LCW'(1);
		cand_dist = HCW'(e_s1 + HCW'(sel_idx) + HCW'(1));
	end

	assign is_match_c = (best_len_q >= LCW'(MIN_MATCH));
	assign n_c        = is_match_c ? best_len_q : LCW'(1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			maxlen_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
				REG_MAXLEN: maxlen_q <= cfg_data[MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: take a byte, search, emit a token, move bytes into history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			limit_q     <= '0;
			n_q         <= '0;
			last_q      <= 1'b0;
			e_q         <= '0;
			e_s1        <= '0;
			step_s1     <= 1'b0;
			flush_s1    <= 1'b0;
			best_len_q  <= '0;
			best_dist_q <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			step_s1  <= 1'b0;
			flush_s1 <= 1'b0;
			if (out_valid_q && token_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if ((step_s1 || flush_s1) && any_dead && (cand_len > best_len_q)) begin
				best_len_q  <= cand_len;
				best_dist_q <= cand_dist;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (count_q < LCW'(LOOKAHEAD)) begin
							count_q <= count_q + LCW'(1);
						end
						last_q  <= byte_in.payload.last_byte;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (code_c) begin
						e_q         <= HCW'(eff_c);
						limit_q     <= lim_c;
						best_len_q  <= '0;
						best_dist_q <= '0;
						state_q     <= ST_SEARCH;
					end else begin
						if (last_q) begin
							wp_q   <= '0;
							fill_q <= '0;
							last_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					e_s1 <= e_q;
					if (e_q != '0) begin
						step_s1 <= 1'b1;
						e_q     <= e_q - HCW'(1);
					end else begin
						flush_s1 <= 1'b1;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_q.token_kind     <= is_match_c ? KIND_MATCH
							: ((la_byte[0] == ESC_BYTE) ? KIND_ESCAPED : KIND_LITERAL);
						out_q.literal_value  <= is_match_c ? '0 : la_byte[0];
						out_q.match_length   <= is_match_c ? LEN_W'(best_len_q) : '0;
						out_q.match_distance <= is_match_c ? DIST_W'(best_dist_q) : '0;
						out_q.last_token     <= last_q && (count_q == n_c);
						out_valid_q          <= 1'b1;
						n_q                  <= n_c;
						state_q              <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					wp_q    <= (wp_q == HAW'(HISTORY - 1)) ? '0 : wp_q + HAW'(1);
					if (fill_q != HCW'(HISTORY)) begin
						fill_q <= fill_q + HCW'(1);
					end
					count_q <= count_q - LCW'(1);
					n_q     <= n_q - LCW'(1);
					if (n_q == LCW'(1)) begin
						state_q <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign token_out.valid   = out_valid_q;
	assign token_out.payload = out_q;

	// Checks on the sequencer and the match search.
	`LZG_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= LCW'(LOOKAHEAD), "lookahead overfilled")
	`LZG_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= HCW'(HISTORY), "history fill overran")
	`LZG_ASSERT_IMPL(a_best_limit, state_q == ST_EMIT, best_len_q <= limit_q, "match too long")
	`LZG_ASSERT_IMPL(a_move_nonempty, state_q == ST_MOVE, (count_q != '0) && (n_q != '0), "empty move")
endmodule
`default_nettype wire

/* src/lzg_cell.sv */
`default_nettype none
module lzg_cell #(
	parameter int IDX = 0,
	parameter int LCW = 6
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lzg_pkg::cell_ctrl_t      ctrl,
	input  wire logic [LCW-1:0]           count,
	input  wire logic [LCW-1:0]           limit,
	input  wire logic [lzg_pkg::BYTE_W-1:0] next_byte,
	input  wire logic                     prev_alive,
	input  wire logic                     next_extend,
	output logic [lzg_pkg::BYTE_W-1:0]    la_byte,
	output logic                          alive,
	output logic                          extend,
	output logic                          dead
);
	import lzg_pkg::*;

	logic [BYTE_W-1:0] la_q;
	logic              alive_q;

	// A run may grow here when the streamed history byte equals this lookahead byte.
	assign extend = ctrl.step && (ctrl.hist_byte == la_q) && (LCW'(IDX) < limit);

	// A live run ends when the next cell cannot take it on.
	assign dead = (ctrl.step || ctrl.flush) && alive_q && !next_extend;

	// Lookahead byte: loaded at the fill position, shifted towards the head on a move.
	always_ff @(posedge clk) begin
		if (ctrl.load && (count == LCW'(IDX))) begin
			la_q <= ctrl.in_byte;
		end else if (ctrl.shift) begin
			la_q <= next_byte;
		end
	end

	// Run flag, handed on from the previous cell every compare cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (ctrl.clear || ctrl.flush) begin
			alive_q <= 1'b0;
		end else if (ctrl.step) begin
			alive_q <= prev_alive && extend;
		end
	end

	assign la_byte = la_q;
	assign alive   = alive_q;
endmodule
`default_nettype wire

/* src/lzg_history_mem.sv */
`default_nettype none
module lzg_history_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [lzg_pkg::BYTE_W-1:0] wdata,
	input  wire logic [AW-1:0]              raddr,
	output logic [lzg_pkg::BYTE_W-1:0]      rdata
);
	import lzg_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire
